// ----- sv/tqi_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Table quadratic interpolator package
// Shared types, constants and controller command/status structures.
// ----------------------------------------------------------------------------
package tqi_pkg;

    localparam int TableDepth = 128;
    localparam int IdxW       = $clog2(TableDepth);
    localparam int CntW       = IdxW + 1;

    localparam logic [1:0] StatOk      = 2'd0;
    localparam logic [1:0] StatFewPts  = 2'd1;
    localparam logic [1:0] StatZeroDiv = 2'd2;

    localparam logic OpWrite  = 1'b0;
    localparam logic OpQuery  = 1'b1;

    typedef enum logic [3:0] {
        t_ST_IDLE,
        t_ST_RD_LO,
        t_ST_RD_HI,
        t_ST_CLAMP,
        t_ST_SEARCH,
        t_ST_LOAD,
        t_ST_DIFF,
        t_ST_DIV,
        t_ST_EVAL,
        t_ST_DONE
    } t_state;

    // datapath division operand selects
    typedef enum logic [1:0] {
        t_DIV_D12,
        t_DIV_D01,
        t_DIV_D012
    } t_div_sel;

    typedef struct packed {
        logic           load_q;     // capture query x
        logic           rd_en;      // issue table read
        logic [IdxW-1:0] rd_addr;
        logic           cap_lo;
        logic           cap_hi;
        logic           clamp;
        logic           cap_pt;     // capture search read as candidate
        logic [1:0]     pt_slot;    // which of x0/x1/x2 receives the read
        logic           diffs;
        logic           div_start;
        t_div_sel       div_sel;
        logic [1:0]     eval_step;
        logic           eval_en;
        logic           clr_zd;
    } t_cmd;

    typedef struct packed {
        logic rd_le;      // read x at or below clamped x
        logic div_busy;
    } t_sts;

endpackage : tqi_pkg
`default_nettype wire

// ----- sv/tqi_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring division one bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module tqi_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_num,
    input  wire logic signed [16:0] i_den,
    output logic                    o_busy,
    output logic signed [31:0]      o_quot
);
    logic [31:0] r_rem_q, n_rem_q;   // shifting dividend / quotient
    logic [31:0] r_rem,   n_rem;
    logic [16:0] r_den;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic [32:0] trial;
    logic [31:0] shifted;

    always_comb begin
        shifted = {r_rem[30:0], r_rem_q[31]};
        trial   = {1'b0, shifted} - {16'd0, r_den};
        n_rem_q = {r_rem_q[30:0], ~trial[32]};
        n_rem   = trial[32] ? shifted : trial[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
        end else if (i_start) begin
            r_cnt <= 6'd32;
        end else if (r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem_q <= i_num[31] ? 32'(-i_num) : i_num;
            r_rem   <= 32'd0;
            r_den   <= i_den[16] ? 17'(-i_den) : i_den;
            r_neg   <= i_num[31] ^ i_den[16];
        end else if (r_cnt != 6'd0) begin
            r_rem_q <= n_rem_q;
            r_rem   <= n_rem;
        end
    end

    assign o_busy = (r_cnt != 6'd0);
    assign o_quot = r_neg ? 32'(-r_rem_q) : r_rem_q;
endmodule
`default_nettype wire

// ----- sv/tqi_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Interpolator datapath
// Point tables, clamp, divided differences and Newton evaluation.
// ----------------------------------------------------------------------------
module tqi_datapath (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_wr_en,
    input  wire logic [tqi_pkg::IdxW-1:0] i_wr_addr,
    input  wire logic signed [15:0]      i_x_value,
    input  wire logic signed [15:0]      i_entry_y,
    input  wire tqi_pkg::t_cmd           i_cmd,
    output tqi_pkg::t_sts                o_sts,
    output logic signed [15:0]           o_y,
    output logic                         o_zd
);
    logic [15:0] r_xmem [tqi_pkg::TableDepth];
    logic [15:0] r_ymem [tqi_pkg::TableDepth];
    logic signed [15:0] r_rdx, r_rdy;

    logic signed [15:0] r_x, r_lo, r_hi;
    logic signed [15:0] r_x0, r_x1, r_x2, r_y0, r_y1, r_y2;
    logic signed [15:0] r_x01, r_x12, r_d01, r_d12, r_d012, r_dx0, r_dx1;
    logic signed [31:0] r_acc, r_prod;
    logic               r_zd;

    logic signed [31:0] div_num, div_q;
    logic signed [16:0] div_den;
    logic               div_busy;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_xmem[i_wr_addr] <= i_x_value;
            r_ymem[i_wr_addr] <= i_entry_y;
        end
        if (i_cmd.rd_en) begin
            r_rdx <= r_xmem[i_cmd.rd_addr];
            r_rdy <= r_ymem[i_cmd.rd_addr];
        end
    end

    always_comb begin
        div_num = 32'sd0;
        div_den = 17'sd0;
        case (i_cmd.div_sel)
            tqi_pkg::t_DIV_D12: begin
                div_num = (32'(r_y2) - 32'(r_y1)) <<< 8;
                div_den = 17'(r_x12);
            end
            tqi_pkg::t_DIV_D01: begin
                div_num = (32'(r_y1) - 32'(r_y0)) <<< 8;
                div_den = 17'(r_x01);
            end
            default: begin
                div_num = (32'(r_d12) - 32'(r_d01)) <<< 8;
                div_den = 17'(r_x01) + 17'(r_x12);
            end
        endcase
    end

    tqi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_q)  r_x  <= i_x_value;
        if (i_cmd.cap_lo)  r_lo <= r_rdx;
        if (i_cmd.cap_hi)  r_hi <= r_rdx;
        if (i_cmd.clamp) begin
            if (r_x < r_lo)      r_x <= r_lo;
            else if (r_x > r_hi) r_x <= r_hi;
        end
        if (i_cmd.cap_pt) begin
            case (i_cmd.pt_slot)
                2'd0:    begin r_x0 <= r_rdx; r_y0 <= r_rdy; end
                2'd1:    begin r_x1 <= r_rdx; r_y1 <= r_rdy; end
                default: begin r_x2 <= r_rdx; r_y2 <= r_rdy; end
            endcase
        end
        if (i_cmd.diffs) begin
            r_x01 <= r_x1 - r_x0;
            r_x12 <= r_x2 - r_x1;
            r_dx0 <= r_x - r_x0;
            r_dx1 <= r_x - r_x1;
        end
        // quotient written back on the cycle after the divider finishes
        if (i_cmd.div_start) begin
            if (div_den == 17'sd0) r_zd <= 1'b1;
        end
        if (i_cmd.clr_zd) r_zd <= 1'b0;
        if (i_cmd.eval_en) begin
            case (i_cmd.eval_step)
                2'd0: begin
                    r_prod <= 32'(r_dx0) * 32'(r_d01);
                    r_acc  <= 32'(r_y0);
                end
                2'd1: begin
                    r_acc  <= r_acc + (r_prod >>> 8);
                    r_prod <= 32'(r_dx0) * 32'(r_dx1);
                end
                2'd2: begin
                    r_prod <= r_prod * 32'(r_d012);
                end
                default: begin
                    r_acc <= r_acc + (r_prod >>> 16);
                end
            endcase
        end
    end

    // capture quotients: the controller holds div_sel with eval_en low
    logic r_busy_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_d <= 1'b0;
        end else begin
            r_busy_d <= div_busy;
        end
        if (r_busy_d && !div_busy) begin
            case (i_cmd.div_sel)
                tqi_pkg::t_DIV_D12: r_d12  <= (div_den == 17'sd0) ? 16'sd0 : div_q[15:0];
                tqi_pkg::t_DIV_D01: r_d01  <= (div_den == 17'sd0) ? 16'sd0 : div_q[15:0];
                default:            r_d012 <= (div_den == 17'sd0) ? 16'sd0 : div_q[15:0];
            endcase
        end
    end

    always_comb begin
        if (r_acc > 32'sd32767)       o_y = 16'sd32767;
        else if (r_acc < -32'sd32768) o_y = -16'sd32768;
        else                          o_y = r_acc[15:0];
    end

    assign o_zd           = r_zd;
    assign o_sts.rd_le    = (r_rdx <= r_x);
    assign o_sts.div_busy = div_busy || r_busy_d;
endmodule
`default_nettype wire

// ----- sv/tqi_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Interpolator controller
// Sequences clamp, backward search, point loads, divisions and evaluation.
// ----------------------------------------------------------------------------
module tqi_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_query,
    input  wire logic [7:0]             i_point_count,
    input  wire tqi_pkg::t_sts          i_sts,
    output tqi_pkg::t_cmd               o_cmd,
    output logic                        o_busy,
    output logic                        o_done,
    output logic                        o_few
);
    tqi_pkg::t_state r_state, n_state;
    logic [tqi_pkg::IdxW-1:0] r_p, n_p, r_last, n_last;
    logic [1:0] r_sub, n_sub;
    logic       r_few, n_few;
    logic [tqi_pkg::CntW-1:0] cnt;

    always_comb begin
        if (i_point_count > 8'(tqi_pkg::TableDepth))
            cnt = tqi_pkg::CntW'(tqi_pkg::TableDepth);
        else
            cnt = tqi_pkg::CntW'(i_point_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tqi_pkg::t_ST_IDLE;
            r_p <= '0; r_last <= '0; r_sub <= '0; r_few <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p <= n_p; r_last <= n_last; r_sub <= n_sub; r_few <= n_few;
        end
    end

    always_comb begin
        n_state = r_state; n_p = r_p; n_last = r_last; n_sub = r_sub; n_few = r_few;
        o_cmd = '0;
        o_cmd.div_sel = tqi_pkg::t_div_sel'(r_sub);
        o_done = 1'b0;
        unique case (r_state)
            tqi_pkg::t_ST_IDLE: begin
                if (i_query) begin
                    o_cmd.load_q = 1'b1;
                    o_cmd.clr_zd = 1'b1;
                    if (cnt < tqi_pkg::CntW'(3)) begin
                        n_few = 1'b1; n_state = tqi_pkg::t_ST_DONE;
                    end else begin
                        n_few = 1'b0;
                        n_last = tqi_pkg::IdxW'(cnt - tqi_pkg::CntW'(1));
                        o_cmd.rd_en = 1'b1; o_cmd.rd_addr = '0;
                        n_state = tqi_pkg::t_ST_RD_LO;
                    end
                end
            end
            tqi_pkg::t_ST_RD_LO: begin
                o_cmd.cap_lo = 1'b1;
                o_cmd.rd_en = 1'b1; o_cmd.rd_addr = r_last;
                n_state = tqi_pkg::t_ST_RD_HI;
            end
            tqi_pkg::t_ST_RD_HI: begin
                o_cmd.cap_hi = 1'b1;
                n_state = tqi_pkg::t_ST_CLAMP;
            end
            tqi_pkg::t_ST_CLAMP: begin
                o_cmd.clamp = 1'b1;
                o_cmd.rd_en = 1'b1; o_cmd.rd_addr = r_last;
                n_p = r_last;
                n_state = tqi_pkg::t_ST_SEARCH;
            end
            tqi_pkg::t_ST_SEARCH: begin
                // read data of r_p is valid here
                if (r_p == '0 || i_sts.rd_le) begin
                    if (r_p >= r_last - tqi_pkg::IdxW'(1))
                        n_p = r_last - tqi_pkg::IdxW'(2);
                    o_cmd.rd_en = 1'b1;
                    o_cmd.rd_addr = (r_p >= r_last - tqi_pkg::IdxW'(1))
                                    ? r_last - tqi_pkg::IdxW'(2) : r_p;
                    n_sub = 2'd0;
                    n_state = tqi_pkg::t_ST_LOAD;
                end else begin
                    n_p = r_p - tqi_pkg::IdxW'(1);
                    o_cmd.rd_en = 1'b1; o_cmd.rd_addr = r_p - tqi_pkg::IdxW'(1);
                end
            end
            tqi_pkg::t_ST_LOAD: begin
                o_cmd.cap_pt = 1'b1; o_cmd.pt_slot = r_sub;
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_addr = r_p + tqi_pkg::IdxW'(r_sub) + tqi_pkg::IdxW'(1);
                if (r_sub == 2'd2) begin
                    n_state = tqi_pkg::t_ST_DIFF;
                end else begin
                    n_sub = r_sub + 2'd1;
                end
            end
            tqi_pkg::t_ST_DIFF: begin
                o_cmd.diffs = 1'b1;
                n_sub = 2'd0;
                n_state = tqi_pkg::t_ST_DIV;
            end
            tqi_pkg::t_ST_DIV: begin
                // start the division selected by r_sub once the divider is free
                if (!i_sts.div_busy) begin
                    o_cmd.div_start = 1'b1;
                    n_state = tqi_pkg::t_ST_EVAL;
                end
            end
            tqi_pkg::t_ST_EVAL: begin
                // wait for quotient capture, then next division or evaluation
                if (!i_sts.div_busy) begin
                    if (r_sub == 2'd2) begin
                        n_sub = 2'd0;
                        n_state = tqi_pkg::t_ST_DONE;
                        o_cmd.eval_en = 1'b1; o_cmd.eval_step = 2'd0;
                        o_cmd.div_sel = tqi_pkg::t_DIV_D012;
                        n_sub = 2'd1;
                        n_few = 1'b0;
                        n_state = tqi_pkg::t_ST_DONE;
                    end else begin
                        n_sub = r_sub + 2'd1;
                        n_state = tqi_pkg::t_ST_DIV;
                    end
                end
            end
            tqi_pkg::t_ST_DONE: begin
                if (r_few || r_sub == 2'd0) begin
                    o_done = 1'b1;
                    n_state = tqi_pkg::t_ST_IDLE;
                end else begin
                    o_cmd.eval_en = 1'b1; o_cmd.eval_step = r_sub;
                    o_cmd.div_sel = tqi_pkg::t_DIV_D012;
                    n_sub = (r_sub == 2'd3) ? 2'd0 : r_sub + 2'd1;
                end
            end
            default: n_state = tqi_pkg::t_ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != tqi_pkg::t_ST_IDLE);
    assign o_few  = r_few;
endmodule
`default_nettype wire

// ----- sv/table_quadratic_interpolator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Table quadratic interpolator
// Three-point Newton interpolation over a table of signed 16-bit points.
// ----------------------------------------------------------------------------
// Usage: set point count through i_cfg_we / i_cfg_data while idle. Raise
// start with an operation; a request is taken when start is high and busy
// is low. A write request stores (x, y) at the index and gives no result;
// writes may follow back to back. A query runs clamp, a backward table
// search (one entry a cycle), three serial divisions and a four-step
// evaluation; the result is shown for one cycle with o_valid, and busy
// falls the cycle after. With fewer than three points the query answers
// status 1 in the cycle after it is taken. Reset clears point count and
// control; the table is undefined until written. The receiver cannot
// stall: each result must be taken in its single cycle.
// ----------------------------------------------------------------------------
module table_quadratic_interpolator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_cfg_we,
    input  wire logic [7:0]         i_cfg_data,
    input  wire logic               i_operation,
    input  wire logic [6:0]         i_entry_index,
    input  wire logic signed [15:0] i_x_value,
    input  wire logic signed [15:0] i_entry_y,
    output logic                    o_valid,
    output logic signed [15:0]      o_y_result,
    output logic [1:0]              o_status
);
    logic [7:0]        r_point_count;
    tqi_pkg::t_cmd     cmd;
    tqi_pkg::t_sts     sts;
    logic              ctrl_busy, done, few, zd, wr_en, query;
    logic signed [15:0] y_dp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= 8'd0;
        end else if (i_cfg_we) begin
            r_point_count <= i_cfg_data;
        end
    end

    assign busy  = ctrl_busy;
    assign wr_en = start && !ctrl_busy && (i_operation == tqi_pkg::OpWrite);
    assign query = start && !ctrl_busy && (i_operation == tqi_pkg::OpQuery);

    tqi_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_query       (query),
        .i_point_count (r_point_count),
        .i_sts         (sts),
        .o_cmd         (cmd),
        .o_busy        (ctrl_busy),
        .o_done        (done),
        .o_few         (few)
    );

    tqi_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_entry_index),
        .i_x_value (i_x_value),
        .i_entry_y (i_entry_y),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_y       (y_dp),
        .o_zd      (zd)
    );

    assign o_valid    = done;
    assign o_y_result = few ? 16'sd0 : y_dp;
    assign o_status   = few ? tqi_pkg::StatFewPts
                      : (zd ? tqi_pkg::StatZeroDiv : tqi_pkg::StatOk);

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result outside query");
    a_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("double result");
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == tqi_pkg::OpQuery) |=> busy)
        else $error("query not taken");
endmodule
`default_nettype wire

// ----- dv/table_quadratic_interpolator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table quadratic interpolator testbench
// Loads point tables of many sizes and shapes, runs write and query requests
// with bursty pacing and checks every result against a local predictor.
// ----------------------------------------------------------------------------
module table_quadratic_interpolator_test;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic signed [15:0] y;
        logic [1:0]         st;
    } t_interp;

    typedef struct {
        t_row_kind   kind;
        logic        op;
        logic [6:0]  idx;
        logic [15:0] x;     // also the point count on a configuration row
        logic [15:0] y;
        bit          typed;
        t_interp     tv;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_cfg_we;
    logic [7:0]         i_cfg_data;
    logic               i_operation;
    logic [6:0]         i_entry_index;
    logic signed [15:0] i_x_value;
    logic signed [15:0] i_entry_y;
    logic               o_valid;
    logic signed [15:0] o_y_result;
    logic [1:0]         o_status;

    logic signed [15:0] table_x [tqi_pkg::TableDepth];
    logic signed [15:0] table_y [tqi_pkg::TableDepth];
    logic [7:0]         point_count;
    t_interp            pending_results[$];
    int                 mismatches;
    int                 burst_left;
    int                 requests_sent;

    table_quadratic_interpolator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_operation   (i_operation),
        .i_entry_index (i_entry_index),
        .i_x_value     (i_x_value),
        .i_entry_y     (i_entry_y),
        .o_valid       (o_valid),
        .o_y_result    (o_y_result),
        .o_status      (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int s16(input int v);
        logic signed [15:0] t;
        t = v[15:0];
        return int'(t);
    endfunction

    function automatic int trunc_div(input int num, input int den, ref bit zero_div);
        if (den == 0) begin
            zero_div = 1'b1;
            return 0;
        end
        return s16(num / den);
    endfunction

    function automatic t_interp predict_interp(input logic signed [15:0] xq);
        int n, last, x, p;
        int x0, x1, x2, y0, y1, y2, x01, x12, d01, d12, d012, dx0, dx1, acc;
        bit zd;
        t_interp r;
        zd = 1'b0;
        n = (int'(point_count) > tqi_pkg::TableDepth) ? tqi_pkg::TableDepth
                                                       : int'(point_count);
        if (n < 3) begin
            r.y = '0;
            r.st = tqi_pkg::StatFewPts;
            return r;
        end
        last = n - 1;
        x = int'(xq);
        // first x is tested before last x, which matters for unordered tables
        if (x < table_x[0]) x = table_x[0];
        else if (x > table_x[last]) x = table_x[last];
        p = last;
        while (p > 0 && table_x[p] > x) p--;
        if (p >= last - 1) p = last - 2;
        x0 = table_x[p];     y0 = table_y[p];
        x1 = table_x[p + 1]; y1 = table_y[p + 1];
        x2 = table_x[p + 2]; y2 = table_y[p + 2];
        x01 = s16(x1 - x0);
        x12 = s16(x2 - x1);
        d12 = trunc_div((y2 - y1) * 256, x12, zd);
        d01 = trunc_div((y1 - y0) * 256, x01, zd);
        d012 = trunc_div((d12 - d01) * 256, x01 + x12, zd);
        dx0 = s16(x - x0);
        dx1 = s16(x - x1);
        acc = y0 + ((dx0 * d01) >>> 8) + (((dx0 * dx1) * d012) >>> 16);
        if (acc > 32767) acc = 32767;
        else if (acc < -32768) acc = -32768;
        r.y = acc[15:0];
        r.st = zd ? tqi_pkg::StatZeroDiv : tqi_pkg::StatOk;
        return r;
    endfunction

    // Issue one request with bursty pacing; return just after the negedge
    // that follows acceptance, start still high.
    task automatic send_request(input logic op, input logic [6:0] idx,
                                input logic [15:0] x, input logic [15:0] y,
                                input bit typed, input t_interp tv);
        int gap;
        bit taken;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        start         <= 1'b1;
        i_operation   <= op;
        i_entry_index <= idx;
        i_x_value     <= x;
        i_entry_y     <= y;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (!busy) begin
                taken = 1'b1;
                if (op == tqi_pkg::OpWrite) begin
                    table_x[idx] = x;
                    table_y[idx] = y;
                end else begin
                    pending_results.push_back(typed ? tv : predict_interp(x));
                end
            end
            @(negedge i_clk);
        end
        requests_sent++;
    endtask

    // Drain, let any trailing write finish, then load the point count.
    task automatic set_point_count(input logic [7:0] value);
        start <= 1'b0;
        while (pending_results.size() > 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        while (busy) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        point_count = value;
        burst_left = 0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result y=%0d status=%0d", o_y_result, o_status);
            end else begin
                t_interp want;
                want = pending_results.pop_front();
                if (o_y_result !== want.y || o_status !== want.st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result: expected y=%0d status=%0d, got y=%0d status=%0d",
                                 want.y, want.st, o_y_result, o_status);
                end
            end
        end
    end

    initial begin
        #50_000_000;
        $display("table_quadratic_interpolator: mismatch");
        $finish;
    end

    initial begin
        t_stim_row directed_rows[$];
        t_interp few;
        int n, m, stepmax, shape, queries, xc;
        int lo_x, hi_x;
        logic [15:0] xr;

        few.y = '0;
        few.st = tqi_pkg::StatFewPts;
        directed_rows = '{
            '{ROW_REQ, tqi_pkg::OpQuery, 7'd0,   16'h8000, 16'h0000, 1'b1, few},
            '{ROW_REQ, tqi_pkg::OpQuery, 7'd127, 16'h7FFF, 16'hFFFF, 1'b1, few},
            '{ROW_CFG, tqi_pkg::OpWrite, 7'd0,   16'd2,    16'h0000, 1'b0, few},
            '{ROW_REQ, tqi_pkg::OpQuery, 7'd0,   16'h0000, 16'h0000, 1'b1, few},
            '{ROW_CFG, tqi_pkg::OpWrite, 7'd0,   16'd3,    16'h0000, 1'b0, few},
            '{ROW_REQ, tqi_pkg::OpWrite, 7'd0,   16'h8000, 16'h7FFF, 1'b0, few},
            '{ROW_REQ, tqi_pkg::OpWrite, 7'd1,   16'h0000, 16'h8000, 1'b0, few},
            '{ROW_REQ, tqi_pkg::OpWrite, 7'd2,   16'h7FFF, 16'h7FFF, 1'b0, few},
            '{ROW_REQ, tqi_pkg::OpQuery, 7'd0,   16'h8000, 16'h0000, 1'b0, few},
            '{ROW_REQ, tqi_pkg::OpQuery, 7'd0,   16'h7FFF, 16'h0000, 1'b0, few},
            '{ROW_REQ, tqi_pkg::OpQuery, 7'd0,   16'h0000, 16'h0000, 1'b0, few},
            '{ROW_REQ, tqi_pkg::OpQuery, 7'd0,   16'hFF9C, 16'h0000, 1'b0, few},
            // repeat the first x to hit the zero divisor
            '{ROW_REQ, tqi_pkg::OpWrite, 7'd1,   16'h8000, 16'h0005, 1'b0, few},
            '{ROW_REQ, tqi_pkg::OpQuery, 7'd0,   16'h0000, 16'h0000, 1'b0, few},
            '{ROW_REQ, tqi_pkg::OpWrite, 7'd127, 16'hFFFF, 16'hFFFF, 1'b0, few},
            // unordered table
            '{ROW_REQ, tqi_pkg::OpWrite, 7'd0,   16'd100,  16'h0000, 1'b0, few},
            '{ROW_REQ, tqi_pkg::OpWrite, 7'd1,   16'hFF9C, 16'd50,   1'b0, few},
            '{ROW_REQ, tqi_pkg::OpWrite, 7'd2,   16'd50,   16'hFFCE, 1'b0, few},
            '{ROW_REQ, tqi_pkg::OpQuery, 7'd0,   16'h0000, 16'h0000, 1'b0, few},
            '{ROW_REQ, tqi_pkg::OpQuery, 7'd0,   16'd200,  16'h0000, 1'b0, few},
            '{ROW_REQ, tqi_pkg::OpQuery, 7'd0,   16'hFF38, 16'h0000, 1'b0, few}
        };

        mismatches = 0;
        burst_left = 0;
        requests_sent = 0;
        point_count = '0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_operation = tqi_pkg::OpWrite;
        i_entry_index = '0;
        i_x_value = '0;
        i_entry_y = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG)
                set_point_count(directed_rows[i].x[7:0]);
            else
                send_request(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].x,
                             directed_rows[i].y, directed_rows[i].typed, directed_rows[i].tv);
        end

        // Random phases: a fresh point count, a full table load, then queries.
        while (requests_sent < 1120) begin
            case ($urandom_range(0, 19))
                0:       n = $urandom_range(0, 2);
                1:       n = 128;
                2:       n = $urandom_range(129, 255);
                default: n = $urandom_range(3, 24);
            endcase
            if (requests_sent < 40) n = 255;
            m = (n > tqi_pkg::TableDepth) ? tqi_pkg::TableDepth : n;
            set_point_count(n[7:0]);
            shape = $urandom_range(0, 9);
            stepmax = (m > 0) ? 65535 / m : 1;
            xc = -32768 + $urandom_range(0, stepmax);
            for (int k = 0; k < m; k++) begin
                if (shape == 0) xr = 16'($urandom());
                else xr = xc[15:0];
                send_request(tqi_pkg::OpWrite, k[6:0], xr, 16'($urandom()), 1'b0, few);
                if (shape == 1 && $urandom_range(0, 3) == 0) xc += 0;
                else xc += $urandom_range(1, stepmax);
            end
            lo_x = (m > 0) ? table_x[0] : -32768;
            hi_x = (m > 0) ? table_x[m - 1] : 32767;
            if (lo_x > hi_x) begin
                lo_x = -32768;
                hi_x = 32767;
            end
            queries = $urandom_range(4, 30);
            for (int k = 0; k < queries; k++) begin
                // overwrite a point now and then to exercise table updates
                if ($urandom_range(0, 7) == 0)
                    send_request(tqi_pkg::OpWrite, 7'($urandom()), 16'($urandom()),
                                 16'($urandom()), 1'b0, few);
                if ($urandom_range(0, 4) == 0) xr = 16'($urandom());
                else xr = 16'($urandom_range(0, hi_x - lo_x) + lo_x);
                send_request(tqi_pkg::OpQuery, 7'($urandom()), xr, 16'($urandom()),
                             1'b0, few);
            end
        end

        start <= 1'b0;
        while (pending_results.size() > 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("table_quadratic_interpolator: match");
        else
            $display("table_quadratic_interpolator: mismatch");
        $finish;
    end

endmodule
